>>> rtl/glu_pkg.sv
package glu_pkg;

  // Operand width; the lcm is twice as wide.
  localparam int OPND_W = 16;
  localparam int LCM_W  = 2 * OPND_W;
  localparam int CNT_W  = $clog2(OPND_W);

  // Stream payload widths, whole bytes.
  localparam int IN_BITS  = 2 * OPND_W;
  localparam int OUT_BITS = OPND_W + LCM_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EUC  = 5'b00010,
    ST_DIVG = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

endpackage

>>> rtl/gcd_lcm_unit_top.sv
// Channel  | Signals                                  | Payload
// ---------+------------------------------------------+-----------------------------------
// input    | s_axis_tvalid / tready / tdata           | first_value, second_value
// result   | m_axis_tvalid / tready / tdata / tuser   | gcd_value, lcm_value; no_divisor
//
// One shared add/subtract unit runs a bit-serial divider and a shift-add multiplier.
// An item runs k Euclid remainder steps, each a bit-serial divide, and then the lcm steps;
// k is 1 up to about 23 for 16-bit operands. A zero second operand goes straight to the result state.
// lcm is computed as (first / gcd) * second, with one bit-serial divide and one shift-add multiply.
// Synchronous active-high reset clears the sequencer and the result valid.
// The input is taken only in the idle state; a finished result waits in the output
// register while the next item is accepted, and the sequencer holds until that slot frees.
module gcd_lcm_unit_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [glu_pkg::IN_BITS-1:0]  s_axis_tdata,   // [15:0] first_value, [31:16] second_value
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [glu_pkg::OUT_BITS-1:0] m_axis_tdata,   // [15:0] gcd_value, [47:16] lcm_value
  output logic                         m_axis_tuser    // [0] no_divisor
);
  import glu_pkg::*;

  state_t              state;
  logic [CNT_W-1:0]    cnt;
  logic                out_valid;

  logic [OPND_W-1:0]   opa, opb;     // original operands
  logic [OPND_W-1:0]   ea, eb;       // Euclid pair; ea holds the gcd once found
  logic [OPND_W-1:0]   acc, low;     // shared shift pair (remainder/quotient, product)
  logic                flag;

  logic [OPND_W-1:0]   out_gcd;
  logic [LCM_W-1:0]    out_lcm;
  logic                out_flag;

  logic [OPND_W-1:0]   first_in, second_in;
  logic                in_xfer, out_free, last;

  // shared adder
  logic [OPND_W:0]     add_x, add_y;
  logic                add_sub;
  logic [OPND_W+1:0]   add_sum;

  logic [OPND_W-1:0]   divisor;
  logic                div_ok;
  logic [OPND_W-1:0]   div_acc, div_low;
  logic [OPND_W-1:0]   mul_acc, mul_low;

  assign first_in  = s_axis_tdata[OPND_W-1:0];
  assign second_in = s_axis_tdata[IN_BITS-1:OPND_W];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign last          = (cnt == CNT_W'(OPND_W - 1));

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_lcm, out_gcd};
  assign m_axis_tuser  = out_flag;

  assign divisor = (state == ST_DIVG) ? ea : eb;

  always_comb begin
    if (state == ST_MUL) begin
      add_sub = 1'b0;
      add_x   = {1'b0, acc};
      add_y   = low[0] ? {1'b0, opb} : '0;
    end else begin
      add_sub = 1'b1;
      add_x   = {acc, low[OPND_W-1]};
      add_y   = {1'b0, divisor};
    end
    add_sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
              + {{(OPND_W+1){1'b0}}, add_sub};
  end

  // restoring divide step: carry out set means no borrow
  assign div_ok  = add_sum[OPND_W+1];
  assign div_acc = div_ok ? add_sum[OPND_W-1:0] : {acc[OPND_W-2:0], low[OPND_W-1]};
  assign div_low = {low[OPND_W-2:0], div_ok};

  // shift-add multiply step: shift the sum down into the low half
  assign mul_acc = add_sum[OPND_W:1];
  assign mul_low = {add_sum[0], low[OPND_W-1:1]};

  // sequencer and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (in_xfer) begin
            state <= (second_in == '0) ? ST_FIN : ST_EUC;
          end
        end
        ST_EUC: begin
          cnt <= cnt + 1'b1;
          if (last && div_acc == '0) begin
            state <= ST_DIVG;
          end
        end
        ST_DIVG: begin
          cnt <= cnt + 1'b1;
          if (last) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt <= cnt + 1'b1;
          if (last) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          opa <= first_in;
          opb <= second_in;
          eb  <= second_in;
          acc <= '0;
          if (second_in == '0) begin
            flag <= 1'b1;
            ea   <= '0;
            low  <= '0;
          end else begin
            flag <= 1'b0;
            ea   <= first_in;
            low  <= first_in;
          end
        end
      end
      ST_EUC: begin
        if (last) begin
          // remainder ready: move the pair on
          ea  <= eb;
          eb  <= div_acc;
          acc <= '0;
          low <= (div_acc == '0) ? opa : eb;
        end else begin
          acc <= div_acc;
          low <= div_low;
        end
      end
      ST_DIVG: begin
        low <= div_low;
        acc <= last ? '0 : div_acc;
      end
      ST_MUL: begin
        acc <= mul_acc;
        low <= mul_low;
      end
      ST_FIN: begin
        if (out_free) begin
          out_gcd  <= ea;
          out_lcm  <= {acc, low};
          out_flag <= flag;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

endmodule
